// ===== rtl/scl_pkg.sv =====
// ----------------------------------------------------------------------------
// scl_pkg
// Shared constants for the serial clock prescaler search block.
// ----------------------------------------------------------------------------
package scl_pkg;

    // field widths
    localparam int TGT_W    = 23;
    localparam int SRC_W    = 32;
    localparam int FIRST_W  = 2;
    localparam int SECOND_W = 6;

    // fixed bus clock factor and source clock after reset
    localparam int unsigned FIXED_FACTOR = 22;
    localparam logic [SRC_W-1:0] SRC_RESET = 32'd111111111;

    // default divider ranges
    localparam int FIRST_DIV_COUNT_DEF  = 4;
    localparam int SECOND_DIV_COUNT_DEF = 64;

    // status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

endpackage

// ===== rtl/scl_div_cell.sv =====
// ----------------------------------------------------------------------------
// scl_div_cell
// One restoring division step: produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scl_div_cell #(
    parameter int NUM_W = 32,
    parameter int DIV_W = 16,
    parameter int Q_W   = 8,
    parameter int SHIFT = 0
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] rem_in,
    input  logic [DIV_W-1:0] div_in,
    input  logic [Q_W-1:0]   q_in,
    output logic [NUM_W-1:0] rem_out,
    output logic [DIV_W-1:0] div_out,
    output logic [Q_W-1:0]   q_out
);
    localparam int EXT_W = NUM_W + DIV_W;

    logic [EXT_W-1:0] rem_ext;
    logic [EXT_W-1:0] div_ext;
    logic             ge;
    logic [NUM_W-1:0] rem_next;
    logic [Q_W-1:0]   q_next;
    logic [NUM_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [Q_W-1:0]   q_reg;

    // compare against shifted divisor and subtract
    always_comb
    begin
        rem_ext  = EXT_W'(rem_in);
        div_ext  = EXT_W'(div_in) << SHIFT;
        ge       = (rem_ext >= div_ext);
        rem_next = ge ? NUM_W'(rem_ext - div_ext) : rem_in;
        q_next   = q_in;
        q_next[SHIFT] = ge;
    end

    // hand over to the next cell
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_in;
        q_reg   <= q_next;
    end

    assign rem_out = rem_reg;
    assign div_out = div_reg;
    assign q_out   = q_reg;

endmodule

// ===== rtl/scl_div_lane.sv =====
// ----------------------------------------------------------------------------
// scl_div_lane
// Row of division cells, most significant quotient bit first.
// ----------------------------------------------------------------------------
module scl_div_lane #(
    parameter int NUM_W = 32,
    parameter int DIV_W = 16,
    parameter int Q_W   = 8
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DIV_W-1:0] div,
    output logic [Q_W-1:0]   quo
);
    logic [NUM_W-1:0] rem_s [0:Q_W];
    logic [DIV_W-1:0] div_s [0:Q_W];
    logic [Q_W-1:0]   q_s   [0:Q_W];

    assign rem_s[0] = num;
    assign div_s[0] = div;
    assign q_s[0]   = '0;

    // one cell per quotient bit
    for (genvar i = 0; i < Q_W; i++)
    begin : g_cell
        scl_div_cell #(
            .NUM_W (NUM_W),
            .DIV_W (DIV_W),
            .Q_W   (Q_W),
            .SHIFT (Q_W - 1 - i)
        ) u_cell (
            .clk     (clk),
            .rem_in  (rem_s[i]),
            .div_in  (div_s[i]),
            .q_in    (q_s[i]),
            .rem_out (rem_s[i+1]),
            .div_out (div_s[i+1]),
            .q_out   (q_s[i+1])
        );
    end

    assign quo = q_s[Q_W];

endmodule

// ===== rtl/scl_pick_cell.sv =====
// ----------------------------------------------------------------------------
// scl_pick_cell
// Compares one lane against the best candidate so far; later lanes win ties.
// ----------------------------------------------------------------------------
module scl_pick_cell #(
    parameter int AW    = 2,
    parameter int BW    = 7,
    parameter int ACH_W = 32,
    parameter int LANE  = 0
) (
    input  logic             clk,
    input  logic             found_in,
    input  logic [ACH_W-1:0] ach_in,
    input  logic [AW-1:0]    a_in,
    input  logic [BW-1:0]    b_in,
    input  logic             cand_ok,
    input  logic [ACH_W-1:0] cand_ach,
    input  logic [BW-1:0]    cand_b,
    output logic             found_out,
    output logic [ACH_W-1:0] ach_out,
    output logic [AW-1:0]    a_out,
    output logic [BW-1:0]    b_out
);
    logic             take;
    logic             found_reg;
    logic [ACH_W-1:0] ach_reg;
    logic [AW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;

    // higher achieved clock means smaller error
    assign take = cand_ok && (!found_in || (cand_ach >= ach_in));

    always_ff @(posedge clk)
    begin
        found_reg <= found_in | take;
        ach_reg   <= take ? cand_ach : ach_in;
        a_reg     <= take ? AW'(LANE) : a_in;
        b_reg     <= take ? cand_b : b_in;
    end

    assign found_out = found_reg;
    assign ach_out   = ach_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;

endmodule

// ===== rtl/scl_delay.sv =====
// ----------------------------------------------------------------------------
// scl_delay
// Shift line that carries item side data alongside the division rows.
// ----------------------------------------------------------------------------
module scl_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] stage_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                stage_reg[i] <= '0;
            end
        end
        else
        begin
            stage_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign dout = stage_reg[DEPTH-1];

endmodule

// ===== rtl/scl_divider_search_top.sv =====
// ----------------------------------------------------------------------------
// scl_divider_search_top
// Serial clock prescaler search: best first and second stage divider pair.
// ----------------------------------------------------------------------------
//  channel   ports                                          handshake
//  request   start, busy, target_clock_hz                   start & !busy
//  result    done, first_divider, second_divider, status    done, one cycle
//  config    cfg_we, cfg_wdata                              cfg_we
//
//  one item per cycle; busy stays low
//  path: stage 1, stage 2, restoring division row for b, stage m, restoring
//  division row for achieved clock, pick row, result; one quotient bit per cell
//  reset loads the source clock with 111111111 and empties the pipeline
//  the receiver cannot stall; every result shows for one cycle
// ----------------------------------------------------------------------------
module scl_divider_search_top #(
    parameter int FIRST_DIV_COUNT  = scl_pkg::FIRST_DIV_COUNT_DEF,
    parameter int SECOND_DIV_COUNT = scl_pkg::SECOND_DIV_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [scl_pkg::SRC_W-1:0]      cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic [scl_pkg::TGT_W-1:0]      target_clock_hz,
    output logic                           done,
    output logic [scl_pkg::FIRST_W-1:0]    first_divider,
    output logic [scl_pkg::SECOND_W-1:0]   second_divider,
    output logic                           status
);
    import scl_pkg::*;

    localparam int N1     = FIRST_DIV_COUNT;
    localparam int N2     = SECOND_DIV_COUNT;
    localparam int AW     = (N1 > 1) ? $clog2(N1) : 1;
    localparam int Q1W    = $clog2(N2 + 1);
    localparam int DEN_W  = TGT_W + $clog2(FIXED_FACTOR * N1 + 1);
    localparam int MW     = $clog2(FIXED_FACTOR * N1 * N2 + 1);
    localparam int CHK_W  = DEN_W + $clog2(N1 * N2 + 2);
    localparam int SIDE1  = 2 + N1;
    localparam int SIDE2  = 2 + N1 + N1 * Q1W;
    localparam int LAT    = 4 + Q1W + SRC_W + N1;

    logic [SRC_W-1:0] src_reg;

    // source clock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= SRC_RESET;
        end
        else if (cfg_we)
        begin
            src_reg <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // stage 1: lane denominators
    logic             s1_valid_reg;
    logic             s1_zero_reg;
    logic [DEN_W-1:0] s1_den_reg [0:N1-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_zero_reg <= (target_clock_hz == '0);
    end

    for (genvar a = 0; a < N1; a++)
    begin : g_den
        always_ff @(posedge clk)
        begin
            s1_den_reg[a] <= DEN_W'(DEN_W'(target_clock_hz)
                             * DEN_W'(FIXED_FACTOR * (a + 1)));
        end
    end

    // stage 2: range checks and division setup
    logic             s2_valid_reg;
    logic             s2_err_reg;
    logic [N1-1:0]    s2_ok_reg;
    logic [SRC_W-1:0] s2_rem_reg;
    logic [DEN_W-1:0] s2_den_reg [0:N1-1];
    logic [CHK_W-1:0] lim_hi;
    logic [CHK_W-1:0] src_ext;

    assign src_ext = CHK_W'(src_reg);
    assign lim_hi  = CHK_W'(s1_den_reg[0]) * CHK_W'(N1 * N2 + 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_err_reg <= s1_zero_reg || (src_ext < CHK_W'(s1_den_reg[0]))
                      || (src_ext >= lim_hi);
        s2_rem_reg <= src_reg - SRC_W'(1);
    end

    for (genvar a = 0; a < N1; a++)
    begin : g_ok
        always_ff @(posedge clk)
        begin
            s2_ok_reg[a]  <= src_ext <= CHK_W'(s1_den_reg[a]) * CHK_W'(N2);
            s2_den_reg[a] <= s1_den_reg[a];
        end
    end

    // second stage settings: floor((src-1)/den) equals b-1
    logic [Q1W-1:0]   q1 [0:N1-1];
    logic [SIDE1-1:0] side1;

    for (genvar a = 0; a < N1; a++)
    begin : g_div1
        scl_div_lane #(
            .NUM_W (SRC_W),
            .DIV_W (DEN_W),
            .Q_W   (Q1W)
        ) u_lane (
            .clk (clk),
            .num (s2_rem_reg),
            .div (s2_den_reg[a]),
            .quo (q1[a])
        );
    end

    scl_delay #(
        .W     (SIDE1),
        .DEPTH (Q1W)
    ) u_side1 (
        .clk   (clk),
        .rst_n (rst_n),
        .din   ({s2_valid_reg, s2_err_reg, s2_ok_reg}),
        .dout  (side1)
    );

    // stage m: full divider 22*(a+1)*b per lane
    logic [SIDE1-1:0] m_side_reg;
    logic [MW-1:0]    m_div_reg [0:N1-1];
    logic [N1*Q1W-1:0] m_q1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_side_reg <= '0;
        end
        else
        begin
            m_side_reg <= side1;
        end
    end

    for (genvar a = 0; a < N1; a++)
    begin : g_mul
        always_ff @(posedge clk)
        begin
            m_div_reg[a] <= MW'((MW'(q1[a]) + MW'(1)) * MW'(FIXED_FACTOR * (a + 1)));
            m_q1_reg[a*Q1W +: Q1W] <= q1[a];
        end
    end

    // achieved clock per lane
    logic [SRC_W-1:0]    ach [0:N1-1];
    logic [SIDE2-1:0]    side2;

    for (genvar a = 0; a < N1; a++)
    begin : g_div2
        scl_div_lane #(
            .NUM_W (SRC_W),
            .DIV_W (MW),
            .Q_W   (SRC_W)
        ) u_lane (
            .clk (clk),
            .num (src_reg),
            .div (m_div_reg[a]),
            .quo (ach[a])
        );
    end

    scl_delay #(
        .W     (SIDE2),
        .DEPTH (SRC_W)
    ) u_side2 (
        .clk   (clk),
        .rst_n (rst_n),
        .din   ({m_side_reg, m_q1_reg}),
        .dout  (side2)
    );

    // pick row: one cell per lane
    logic                 pk_valid [0:N1];
    logic                 pk_err   [0:N1];
    logic [N1-1:0]        pk_ok    [0:N1];
    logic [N1*Q1W-1:0]    pk_q1    [0:N1];
    logic [N1*SRC_W-1:0]  pk_ach   [0:N1];
    logic                 pk_found [0:N1];
    logic [SRC_W-1:0]     pk_best  [0:N1];
    logic [AW-1:0]        pk_a     [0:N1];
    logic [Q1W-1:0]       pk_b     [0:N1];

    assign pk_valid[0] = side2[SIDE2-1];
    assign pk_err[0]   = side2[SIDE2-2];
    assign pk_ok[0]    = side2[N1*Q1W +: N1];
    assign pk_q1[0]    = side2[N1*Q1W-1:0];
    assign pk_found[0] = 1'b0;
    assign pk_best[0]  = '0;
    assign pk_a[0]     = AW'(N1 - 1);
    assign pk_b[0]     = Q1W'(N2 - 1);

    for (genvar a = 0; a < N1; a++)
    begin : g_ach
        assign pk_ach[0][a*SRC_W +: SRC_W] = ach[a];
    end

    for (genvar k = 0; k < N1; k++)
    begin : g_pick
        scl_pick_cell #(
            .AW    (AW),
            .BW    (Q1W),
            .ACH_W (SRC_W),
            .LANE  (k)
        ) u_pick (
            .clk       (clk),
            .found_in  (pk_found[k]),
            .ach_in    (pk_best[k]),
            .a_in      (pk_a[k]),
            .b_in      (pk_b[k]),
            .cand_ok   (pk_ok[k][k]),
            .cand_ach  (pk_ach[k][k*SRC_W +: SRC_W]),
            .cand_b    (pk_q1[k][k*Q1W +: Q1W]),
            .found_out (pk_found[k+1]),
            .ach_out   (pk_best[k+1]),
            .a_out     (pk_a[k+1]),
            .b_out     (pk_b[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pk_valid[k+1] <= 1'b0;
            end
            else
            begin
                pk_valid[k+1] <= pk_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            pk_err[k+1] <= pk_err[k];
            pk_ok[k+1]  <= pk_ok[k];
            pk_q1[k+1]  <= pk_q1[k];
            pk_ach[k+1] <= pk_ach[k];
        end
    end

    // result register
    logic                done_reg;
    logic                status_reg;
    logic [FIRST_W-1:0]  first_reg;
    logic [SECOND_W-1:0] second_reg;
    logic [AW+FIRST_W-1:0]   a_wide;
    logic [Q1W+SECOND_W-1:0] b_wide;

    assign a_wide = (AW + FIRST_W)'(pk_a[N1]);
    assign b_wide = (Q1W + SECOND_W)'(pk_b[N1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pk_valid[N1];
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= pk_err[N1] ? STATUS_RANGE : STATUS_OK;
        first_reg  <= pk_err[N1] ? '0 : a_wide[FIRST_W-1:0];
        second_reg <= pk_err[N1] ? '0 : b_wide[SECOND_W-1:0];
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign first_divider  = first_reg;
    assign second_divider = second_reg;

`ifndef NO_ASSERTIONS
    // every accepted item yields its result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after pipeline latency");

    // an out of range status carries zero settings
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_RANGE)) |->
        ((first_divider == '0) && (second_divider == '0)))
        else $error("range error with nonzero settings");

    // no result without a matching item in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pk_valid[N1]))
        else $error("result without an item");
`endif

endmodule
